// ===== sv/assert_macros.svh =====
// Assertion macros used by the top-level RTL file of the pulse clock divider fit block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_HOLDS(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_HOLDS(lbl, clk, rst_n, expr)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== sv/pcdf_pkg.sv =====
// Package with widths, the bit period table and shared types of the divider fit block.
package pcdf_pkg;

  localparam int DUR_W              = 20;
  localparam int DIV_W              = 9;
  localparam int CNT_OUT_W          = 8;
  localparam int PER_W              = 10;
  localparam int CNT_MAX_W          = 13;
  localparam int NUM_PERIODS        = 11;
  localparam int IDX_W              = 4;
  localparam int DEF_MAX_PULSE_BITS = 224;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LAUNCH,
    ST_WAIT,
    ST_OUTPUT
  } pcdf_state_t;

  typedef struct packed {
    logic                 done;
    logic [CNT_MAX_W-1:0] quot;
    logic [DUR_W-1:0]     rem;
  } div_stat_t;

  function automatic logic [PER_W-1:0] period_of(input logic [IDX_W-1:0] idx);
    logic [PER_W-1:0] p;
    case (idx)
      4'd0:    p = 10'd4;
      4'd1:    p = 10'd8;
      4'd2:    p = 10'd10;
      4'd3:    p = 10'd20;
      4'd4:    p = 10'd40;
      4'd5:    p = 10'd80;
      4'd6:    p = 10'd100;
      4'd7:    p = 10'd200;
      4'd8:    p = 10'd250;
      4'd9:    p = 10'd500;
      4'd10:   p = 10'd1000;
      default: p = 10'd4;
    endcase
    return p;
  endfunction

endpackage

// ===== sv/pcdf_div.sv =====
// Iterative restoring divider that yields the clamped bit count and remainder for one period.
module pcdf_div
  import pcdf_pkg::*;
#(
  parameter int MAX_PULSE_BITS = DEF_MAX_PULSE_BITS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DUR_W-1:0] dividend,
  input  logic [PER_W-1:0] period,
  output div_stat_t        stat
);

  localparam int CW = $clog2(MAX_PULSE_BITS + 1);
  localparam int BW = (CW > 1) ? $clog2(CW) : 1;
  localparam int SW = (DUR_W > PER_W + CW) ? DUR_W : PER_W + CW;

  logic             active_r, active_nxt;
  logic             done_r, done_nxt;
  logic [BW-1:0]    bit_r, bit_nxt;
  logic [CW-1:0]    quot_r, quot_nxt;
  logic [DUR_W-1:0] rem_r, rem_nxt;
  logic [PER_W-1:0] period_r, period_nxt;

  logic [SW-1:0]    shifted;
  logic [CW-1:0]    trial;
  logic             fits;

  always_comb begin
    shifted = SW'(period_r) << bit_r;
    trial   = quot_r | (CW'(1) << bit_r);
    fits    = (shifted <= SW'(rem_r)) && (trial <= CW'(MAX_PULSE_BITS));
  end

  always_comb begin
    active_nxt = active_r;
    done_nxt   = 1'b0;
    bit_nxt    = bit_r;
    quot_nxt   = quot_r;
    rem_nxt    = rem_r;
    period_nxt = period_r;
    if (start) begin
      active_nxt = 1'b1;
      bit_nxt    = BW'(CW - 1);
      quot_nxt   = '0;
      rem_nxt    = dividend;
      period_nxt = period;
    end else if (active_r) begin
      if (fits) begin
        quot_nxt = trial;
        rem_nxt  = rem_r - shifted[DUR_W-1:0];
      end
      if (bit_r == '0) begin
        active_nxt = 1'b0;
        done_nxt   = 1'b1;
      end else begin
        bit_nxt = bit_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      done_r   <= 1'b0;
    end else begin
      active_r <= active_nxt;
      done_r   <= done_nxt;
    end
    bit_r    <= bit_nxt;
    quot_r   <= quot_nxt;
    rem_r    <= rem_nxt;
    period_r <= period_nxt;
  end

  assign stat.done = done_r;
  assign stat.quot = CNT_MAX_W'(quot_r);
  assign stat.rem  = rem_r;

endmodule

// ===== sv/pulse_clock_divider_fit.sv =====
// Top level of the pulse clock divider fit block: sequencer, best-fit tracking and output register.
// A duration is fitted by the shared restoring divider, which settles one quotient bit per cycle
// for each of the eleven bit periods in turn; C = clog2(MAX_PULSE_BITS + 1) is the number of
// quotient bits, 8 with the default of 224. Each period has a launch step, the quotient bits and
// a done step, and the output register is loaded after the last period. The input is ready again
// the cycle after the result is loaded. The input is not ready while a duration is being fitted;
// a finished result waits in the output register and the next duration may be taken while it does.
`include "assert_macros.svh"
module pulse_clock_divider_fit
  import pcdf_pkg::*;
#(
  parameter int MAX_PULSE_BITS = DEF_MAX_PULSE_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [19:0] duration_ns, [23:20] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // [8:0] clock_divider, [16:9] bit_count, [23:17] zero
);

  pcdf_state_t          state_r, state_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic [DUR_W-1:0]     dur_r, dur_nxt;
  logic [DUR_W-1:0]     best_err_r, best_err_nxt;
  logic [DIV_W-1:0]     best_div_r, best_div_nxt;
  logic [CNT_MAX_W-1:0] best_cnt_r, best_cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [23:0]          out_data_r, out_data_nxt;

  logic                 div_start;
  logic                 load_out;
  logic                 take_in;
  logic                 better;
  logic [PER_W-1:0]     cur_period;
  div_stat_t            div_stat;

  assign cur_period = period_of(idx_r);
  assign better     = (idx_r == '0) || (div_stat.rem < best_err_r);

  pcdf_div #(
    .MAX_PULSE_BITS(MAX_PULSE_BITS)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(dur_r),
    .period  (cur_period),
    .stat    (div_stat)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_tvalid) state_nxt = ST_LAUNCH;
      ST_LAUNCH: state_nxt = ST_WAIT;
      ST_WAIT: begin
        if (div_stat.done) begin
          state_nxt = (idx_r == IDX_W'(NUM_PERIODS - 1)) ? ST_OUTPUT : ST_LAUNCH;
        end
      end
      ST_OUTPUT: if (!out_valid_r || out_tready) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    div_start = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      ST_IDLE:   in_tready = 1'b1;
      ST_LAUNCH: div_start = 1'b1;
      ST_WAIT:   ;
      ST_OUTPUT: load_out = !out_valid_r || out_tready;
      default:   ;
    endcase
  end

  assign take_in = in_tvalid && in_tready;

  always_comb begin
    idx_nxt       = idx_r;
    dur_nxt       = dur_r;
    best_err_nxt  = best_err_r;
    best_div_nxt  = best_div_r;
    best_cnt_nxt  = best_cnt_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (take_in) begin
      dur_nxt = in_tdata[DUR_W-1:0];
      idx_nxt = '0;
    end
    if (state_r == ST_WAIT && div_stat.done) begin
      if (better) begin
        best_err_nxt = div_stat.rem;
        best_div_nxt = DIV_W'(cur_period >> 1);
        best_cnt_nxt = div_stat.quot;
      end
      idx_nxt = idx_r + 1'b1;
    end
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (load_out) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {7'b0, best_cnt_r[CNT_OUT_W-1:0], best_div_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r      <= idx_nxt;
    dur_r      <= dur_nxt;
    best_err_r <= best_err_nxt;
    best_div_r <= best_div_nxt;
    best_cnt_r <= best_cnt_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `ASSERT_NEXT(a_accept_launches, clk, rst_n, take_in, state_r == ST_LAUNCH)
  `ASSERT_HOLDS(a_done_in_wait, clk, rst_n, !div_stat.done || state_r == ST_WAIT)
  `ASSERT_HOLDS(a_count_clamped, clk, rst_n, state_r != ST_OUTPUT || best_cnt_r <= CNT_MAX_W'(MAX_PULSE_BITS))

endmodule
